// ===== hw/rtl/byte_ring_fifo_offset_read_defines.svh =====
// Assertion helpers shared by the RTL.
`ifndef BYTE_RING_FIFO_OFFSET_READ_DEFINES_SVH
`define BYTE_RING_FIFO_OFFSET_READ_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BRF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define BRF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/brf_pkg.sv =====
package brf_pkg;

  localparam int unsigned DEPTH    = 1024;
  localparam int unsigned MAX_READ = 64;

  localparam int unsigned PTR_W  = $clog2(DEPTH);
  localparam int unsigned SIZE_W = 11;
  localparam int unsigned LEN_W  = 7;
  localparam int unsigned CNT_W  = 10;
  localparam int unsigned MODE_W = 3;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned OFS_W  = 10;

  typedef enum logic [MODE_W-1:0] {
    OP_PUSH  = 3'd0,
    OP_POP   = 3'd1,
    OP_PEEK  = 3'd2,
    OP_SKIP  = 3'd3,
    OP_LEN   = 3'd4,
    OP_CLEAR = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_OFFSET = 2'd1,
    STAT_FULL   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASS,
    ST_EXEC,
    ST_PREP,
    ST_READ
  } state_e;

  typedef struct packed {
    op_e               op;
    logic [DATA_W-1:0] data;
    logic [OFS_W-1:0]  offset;
    logic [LEN_W-1:0]  rlen;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

endpackage

// ===== hw/rtl/brf_front.sv =====
module brf_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [brf_pkg::MODE_W-1:0]  mode_i,
  input  logic [brf_pkg::DATA_W-1:0]  data_byte_i,
  input  logic [brf_pkg::OFS_W-1:0]   offset_i,
  input  logic [brf_pkg::LEN_W-1:0]   read_length_i,
  output brf_pkg::queue_head_t        head_o,
  input  logic                        take_i
);

  brf_pkg::cmd_t ent_q [2];
  logic          wr_q, rd_q;
  logic [1:0]    cnt_q;
  logic          known, enq, deq;
  brf_pkg::cmd_t cmd;

  assign busy  = (cnt_q == 2'd2);
  // modes past clear carry no work and never enter the queue
  assign known = (mode_i <= brf_pkg::MODE_W'(brf_pkg::OP_CLEAR));
  assign enq   = start && !busy && known;
  assign deq   = take_i && (cnt_q != 2'd0);

  always_comb begin
    cmd.op     = brf_pkg::op_e'(mode_i);
    cmd.data   = data_byte_i;
    cmd.offset = offset_i;
    cmd.rlen   = read_length_i;
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.cmd   = ent_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (enq) begin
      ent_q[wr_q] <= cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (enq) wr_q <= ~wr_q;
      if (deq) rd_q <= ~rd_q;
      if (enq && !deq) cnt_q <= cnt_q + 2'd1;
      else if (deq && !enq) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

// ===== hw/rtl/brf_back.sv =====
module brf_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  brf_pkg::queue_head_t        head_i,
  output logic                        take_o,
  input  logic                        cfg_we_i,
  input  logic [brf_pkg::SIZE_W-1:0]  cfg_data_i,
  output logic                        result_strobe_o,
  output logic [brf_pkg::DATA_W-1:0]  data_byte_out_o,
  output logic [brf_pkg::CNT_W-1:0]   count_o,
  output logic [1:0]                  status_o,
  output logic                        last_o
);

  localparam int unsigned PTR_W  = brf_pkg::PTR_W;
  localparam int unsigned SIZE_W = brf_pkg::SIZE_W;
  localparam int unsigned LEN_W  = brf_pkg::LEN_W;
  localparam int unsigned CNT_W  = brf_pkg::CNT_W;

  logic [brf_pkg::DATA_W-1:0] mem [brf_pkg::DEPTH];

  brf_pkg::state_e  state_q, state_d;
  brf_pkg::cmd_t    cmd_q;
  logic [SIZE_W-1:0] ring_q;
  logic [PTR_W-1:0] wp_q, rp_q, stored_q, start_q, avail_q, addr_q;
  logic [LEN_W-1:0] len_q, left_q;
  logic             emit_q, rd_pend_q, rd_last_q;
  logic [CNT_W-1:0] emit_cnt_q;
  brf_pkg::status_e emit_stat_q;
  logic [brf_pkg::DATA_W-1:0] rdata_q;

  logic [SIZE_W-1:0] stored_d, ring_d;
  logic [PTR_W-1:0]  nwp, n_skip;
  logic              is_read, rd_fail, push_full;
  logic [LEN_W-1:0]  rl, len_d;

  // pointer add inside the ring; both operands are below the ring size
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] a,
                                                input logic [PTR_W-1:0] b,
                                                input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] sum;
    sum = SIZE_W'(a) + SIZE_W'(b);
    if (sum >= s) sum = sum - s;
    return sum[PTR_W-1:0];
  endfunction

  always_comb begin
    if (wp_q >= rp_q) stored_d = SIZE_W'(wp_q) - SIZE_W'(rp_q);
    else              stored_d = ring_q - SIZE_W'(rp_q) + SIZE_W'(wp_q);
  end

  always_comb begin
    if (cfg_data_i < SIZE_W'(2))                      ring_d = SIZE_W'(2);
    else if (cfg_data_i > SIZE_W'(brf_pkg::DEPTH))    ring_d = SIZE_W'(brf_pkg::DEPTH);
    else                                              ring_d = cfg_data_i;
  end

  assign nwp       = wrap_add(wp_q, PTR_W'(1), ring_q);
  assign push_full = (nwp == rp_q);
  assign is_read   = (cmd_q.op == brf_pkg::OP_POP) || (cmd_q.op == brf_pkg::OP_PEEK);
  assign rd_fail   = (stored_q == '0) || (PTR_W'(cmd_q.offset) > stored_q);
  assign n_skip    = (PTR_W'(cmd_q.offset) < stored_q) ? PTR_W'(cmd_q.offset) : stored_q;
  assign rl        = (cmd_q.rlen > LEN_W'(brf_pkg::MAX_READ)) ?
                     LEN_W'(brf_pkg::MAX_READ) : cmd_q.rlen;
  assign len_d     = (SIZE_W'(rl) > SIZE_W'(avail_q)) ? LEN_W'(avail_q) : rl;

  always_comb begin
    state_d = state_q;
    take_o  = 1'b0;
    case (state_q)
      brf_pkg::ST_IDLE: begin
        if (head_i.valid) begin
          take_o  = 1'b1;
          state_d = brf_pkg::ST_CLASS;
        end
      end
      brf_pkg::ST_CLASS: state_d = brf_pkg::ST_EXEC;
      brf_pkg::ST_EXEC: begin
        if (is_read && !rd_fail) state_d = brf_pkg::ST_PREP;
        else                     state_d = brf_pkg::ST_IDLE;
      end
      brf_pkg::ST_PREP: begin
        if (len_d == '0) state_d = brf_pkg::ST_IDLE;
        else             state_d = brf_pkg::ST_READ;
      end
      brf_pkg::ST_READ: begin
        if (left_q == LEN_W'(1)) state_d = brf_pkg::ST_IDLE;
      end
      default: state_d = brf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= brf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (state_q == brf_pkg::ST_EXEC && cmd_q.op == brf_pkg::OP_PUSH && !push_full) begin
      mem[wp_q] <= cmd_q.data;
    end
    if (state_q == brf_pkg::ST_READ) begin
      rdata_q <= mem[addr_q];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (take_o) cmd_q <= head_i.cmd;
    if (state_q == brf_pkg::ST_CLASS) stored_q <= stored_d[PTR_W-1:0];
    if (state_q == brf_pkg::ST_EXEC) begin
      start_q <= wrap_add(rp_q, PTR_W'(cmd_q.offset), ring_q);
      avail_q <= stored_q - PTR_W'(cmd_q.offset);
    end
    if (state_q == brf_pkg::ST_PREP) begin
      len_q  <= len_d;
      left_q <= len_d;
      addr_q <= start_q;
    end
    if (state_q == brf_pkg::ST_READ) begin
      left_q    <= left_q - LEN_W'(1);
      addr_q    <= wrap_add(addr_q, PTR_W'(1), ring_q);
      rd_last_q <= (left_q == LEN_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_q      <= SIZE_W'(brf_pkg::DEPTH);
      wp_q        <= '0;
      rp_q        <= '0;
      emit_q      <= 1'b0;
      emit_cnt_q  <= '0;
      emit_stat_q <= brf_pkg::STAT_OK;
      rd_pend_q   <= 1'b0;
    end else begin
      emit_q    <= 1'b0;
      rd_pend_q <= (state_q == brf_pkg::ST_READ);
      if (cfg_we_i) begin
        ring_q <= ring_d;
        wp_q   <= '0;
        rp_q   <= '0;
      end
      if (state_q == brf_pkg::ST_EXEC) begin
        emit_cnt_q  <= '0;
        emit_stat_q <= brf_pkg::STAT_OK;
        case (cmd_q.op)
          brf_pkg::OP_PUSH: begin
            emit_q <= 1'b1;
            if (push_full) begin
              emit_stat_q <= brf_pkg::STAT_FULL;
            end else begin
              wp_q       <= nwp;
              emit_cnt_q <= CNT_W'(1);
            end
          end
          brf_pkg::OP_POP, brf_pkg::OP_PEEK: begin
            if (rd_fail) begin
              emit_q <= 1'b1;
              // empty ring reports ok even with a large offset
              if (stored_q != '0) emit_stat_q <= brf_pkg::STAT_OFFSET;
            end
          end
          brf_pkg::OP_SKIP: begin
            emit_q     <= 1'b1;
            emit_cnt_q <= CNT_W'(n_skip);
            rp_q       <= wrap_add(rp_q, n_skip, ring_q);
          end
          brf_pkg::OP_LEN: begin
            emit_q     <= 1'b1;
            emit_cnt_q <= CNT_W'(stored_q);
          end
          brf_pkg::OP_CLEAR: begin
            emit_q <= 1'b1;
            wp_q   <= '0;
            rp_q   <= '0;
          end
          default: emit_q <= 1'b0;
        endcase
      end
      if (state_q == brf_pkg::ST_PREP) begin
        if (cmd_q.op == brf_pkg::OP_POP) begin
          rp_q <= wrap_add(start_q, PTR_W'(len_d), ring_q);
        end
        if (len_d == '0) begin
          emit_q      <= 1'b1;
          emit_cnt_q  <= '0;
          emit_stat_q <= brf_pkg::STAT_OK;
        end
      end
    end
  end

  assign result_strobe_o = emit_q || rd_pend_q;
  assign data_byte_out_o = rd_pend_q ? rdata_q : '0;
  assign count_o         = rd_pend_q ? CNT_W'(len_q) : emit_cnt_q;
  assign status_o        = rd_pend_q ? brf_pkg::STAT_OK : emit_stat_q;
  assign last_o          = rd_pend_q ? rd_last_q : emit_q;

endmodule

// ===== hw/rtl/byte_ring_fifo_offset_read.sv =====
// Circular byte FIFO with offset reads; one ring slot always stays empty.
// Command channel: a word is taken on a clock edge with start high and busy
// low. mode selects push, pop, peek, skip, length or clear; modes 6 and 7
// are taken and dropped without a result.
// Results: one word per cycle while result_strobe_o is high; the receiver
// has no back pressure. Pop and peek give one word per byte read, last_o on
// the last; a byteless read or any other command gives one word, last_o set.
// Flow: a two-entry command queue sits in front of the executor, so up to
// two commands wait while one runs. The executor takes the queue head when
// idle and steps through class and exec; push, skip, length, clear and a
// refused read give their result from exec. Other reads go on to prep, which
// gives the result of a read that yields nothing, and then to read, which
// shows one byte per cycle from the registered read port of the byte store.
// No new command leaves the queue until the executor is back in idle.
// Config: cfg_size_in_use_i sets the ring size (clamped to 2..1024) and
// empties the FIFO; write it only while no command is in flight.
// Reset: both pointers go to zero, the ring size to 1024, the queue empties.
// Store contents are not cleared; only pushed bytes are ever read back.
`include "byte_ring_fifo_offset_read_defines.svh"

module byte_ring_fifo_offset_read (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [brf_pkg::MODE_W-1:0]  mode_i,
  input  logic [brf_pkg::DATA_W-1:0]  data_byte_i,
  input  logic [brf_pkg::OFS_W-1:0]   offset_i,
  input  logic [brf_pkg::LEN_W-1:0]   read_length_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [brf_pkg::SIZE_W-1:0]  cfg_size_in_use_i,
  output logic                        result_strobe_o,
  output logic [brf_pkg::DATA_W-1:0]  data_byte_out_o,
  output logic [brf_pkg::CNT_W-1:0]   count_o,
  output logic [1:0]                  status_o,
  output logic                        last_o
);

  brf_pkg::queue_head_t head;
  logic                 take;

  assign cfg_ready_o = 1'b1;

  brf_front u_front (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .mode_i,
    .data_byte_i,
    .offset_i,
    .read_length_i,
    .head_o (head),
    .take_i (take)
  );

  brf_back u_back (
    .clk_i,
    .rst_ni,
    .head_i          (head),
    .take_o          (take),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_data_i      (cfg_size_in_use_i),
    .result_strobe_o,
    .data_byte_out_o,
    .count_o,
    .status_o,
    .last_o
  );

  `BRF_ASSERT_NOW(a_busy_has_head, busy, head.valid, "busy with empty command queue")
  `BRF_ASSERT_NOW(a_last_strobed, last_o, result_strobe_o, "last without result strobe")
  `BRF_ASSERT_NOW(a_err_single, result_strobe_o && (status_o != brf_pkg::STAT_OK),
                  last_o && (count_o == '0), "error result not a lone zero-count word")
  `BRF_ASSERT_NEXT(a_read_burst, result_strobe_o && !last_o, result_strobe_o,
                   "gap inside a read burst")

endmodule
